// ----- hdl/dchf_pkg.sv -----
// Shared types and constants for the stereo FIR block.
package dchf_pkg;

    localparam int SAMPLE_W    = 17;
    localparam int COEF_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int CODE_W      = 16;
    localparam int CIDX_W      = 7;
    localparam int P1_W        = SAMPLE_W + COEF_W;
    localparam int P2_W        = P1_W + GAIN_W + 1;
    localparam int SCALE_SHIFT = 27;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CODE_W-1:0] OFFSET8  = 16'd127;
    localparam logic [CODE_W-1:0] OFFSET16 = 16'd32767;
    localparam logic [CODE_W-1:0] TOP8     = 16'd255;
    localparam logic [CODE_W-1:0] TOP16    = 16'd65535;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_TAIL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_EARS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2048;

    typedef struct packed {
        logic [1:0]               operation;
        logic [CODE_W-1:0]        left_code;
        logic [CODE_W-1:0]        right_code;
        logic [CIDX_W-1:0]        coef_index;
        logic                     coef_ear;
        logic signed [COEF_W-1:0] coef_value;
    } s_payload_t;

    typedef struct packed {
        logic [CODE_W-1:0] left_out;
        logic [CODE_W-1:0] right_out;
    } m_payload_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } hist_pair_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] right;
        logic signed [COEF_W-1:0] left;
    } tap_pair_t;

    typedef struct packed {
        logic clear;
        logic dv;
        logic fin1;
        logic fin2;
    } lane_ctrl_t;

endpackage

// ----- hdl/dchf_mem.sv -----
// History and tap memories with fill-count masking of unwritten history.
module dchf_mem
    import dchf_pkg::*;
#(
    parameter int TAPS = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     hist_we,
    input  logic [$clog2(TAPS)-1:0]  hist_waddr,
    input  hist_pair_t               hist_wdata,
    input  logic [1:0]               tap_we,
    input  logic [$clog2(TAPS)-1:0]  tap_waddr,
    input  logic signed [COEF_W-1:0] tap_wdata,
    input  logic                     rd_en,
    input  logic [$clog2(TAPS)-1:0]  hist_raddr,
    input  logic [$clog2(TAPS)-1:0]  tap_raddr,
    output hist_pair_t               hist_q,
    output tap_pair_t                tap_q
);

    localparam int PW = $clog2(TAPS);

    hist_pair_t hist_mem [TAPS];
    tap_pair_t  tap_mem  [TAPS];

    logic [PW:0] fill_reg, fill_next;
    hist_pair_t  hist_q_reg;
    tap_pair_t   tap_q_reg;
    logic        hvalid_reg;

    // entries at or above the fill count were never written since reset
    always_comb begin
        fill_next = fill_reg;
        if (hist_we && (fill_reg != (PW+1)'(TAPS))) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (tap_we[0]) begin
            tap_mem[tap_waddr].left <= tap_wdata;
        end
        if (tap_we[1]) begin
            tap_mem[tap_waddr].right <= tap_wdata;
        end
        if (rd_en) begin
            hist_q_reg <= hist_mem[hist_raddr];
            tap_q_reg  <= tap_mem[tap_raddr];
            hvalid_reg <= ({1'b0, hist_raddr} < fill_reg);
        end
    end

    assign hist_q = hvalid_reg ? hist_q_reg : '0;
    assign tap_q  = tap_q_reg;

endmodule

// ----- hdl/dchf_lane.sv -----
// One ear's MAC lane: product, gain product, accumulate, truncate and clamp.
module dchf_lane
    import dchf_pkg::*;
#(
    parameter int TAPS = 128
) (
    input  logic                       aclk,
    input  lane_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [COEF_W-1:0]   tap,
    input  logic [GAIN_W-1:0]          gain,
    input  logic                       mode16,
    output logic [CODE_W-1:0]          result
);

    localparam int AW = P2_W + $clog2(TAPS) + 1;
    localparam int MW = AW - SCALE_SHIFT;

    logic signed [P1_W-1:0] p1_reg;
    logic signed [P2_W-1:0] p2_reg;
    logic                   v1_reg, v2_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [AW-1:0]          abs_val;
    logic [MW-1:0]          mag_reg;
    logic                   neg_reg;
    logic [CODE_W-1:0]      res_reg, res_next;
    logic [CODE_W-1:0]      off, top, head;

    // gain is folded into each product; the sum is unchanged before the final shift
    always_ff @(posedge aclk) begin
        p1_reg <= sample * tap;
        p2_reg <= p1_reg * $signed({1'b0, gain});
        if (ctrl.clear) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= ctrl.dv;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                acc_reg <= acc_reg + {{(AW-P2_W){p2_reg[P2_W-1]}}, p2_reg};
            end
        end
    end

    assign abs_val = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.fin1) begin
            neg_reg <= acc_reg[AW-1];
            mag_reg <= abs_val[AW-1:SCALE_SHIFT];
        end
        if (ctrl.fin2) begin
            res_reg <= res_next;
        end
    end

    assign off  = mode16 ? OFFSET16 : OFFSET8;
    assign top  = mode16 ? TOP16 : TOP8;
    assign head = top - off;

    always_comb begin
        if (neg_reg) begin
            res_next = (mag_reg > MW'(off)) ? '0 : off - mag_reg[CODE_W-1:0];
        end else begin
            res_next = (mag_reg > MW'(head)) ? top : off + mag_reg[CODE_W-1:0];
        end
    end

    assign result = res_reg;

endmodule

// ----- hdl/dual_channel_hrtf_fir.sv -----
// Top level of the stereo FIR: request handling, sequencer, config and output register.
// A sample or tail request steps through the RUN, DRAIN, FIN1, FIN2 and DONE states after acceptance;
//   no new request is taken until its result has moved to the output register, as the single
//   history/tap read port feeds one MAC per ear per cycle while in RUN.
// A coefficient write and an unused operation code leave the block ready for the next request.
// Synchronous active-low reset clears pointer, fill count, config and control;
//   unwritten history reads as zero through the fill count, so there is no clearing pass.
module dual_channel_hrtf_fir
    import dchf_pkg::*;
#(
    parameter int TAPS = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  s_payload_t            s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output m_payload_t            m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = $clog2(TAPS);
    localparam int IW = (PW > CIDX_W) ? PW : CIDX_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RUN   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_FIN1  = 6'b001000,
        ST_FIN2  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic              mode_reg, swap_reg;
    logic [GAIN_W-1:0] lgain_reg, rgain_reg;

    // history pointer: next slot to write; head is the slot of the newest sample
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] head_reg;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [1:0]    drain_reg, drain_next;
    logic          rd_v_reg;

    logic       m_valid_reg;
    m_payload_t m_data_reg;

    logic accept, acc_push, acc_coef;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign acc_push  = accept && ((s_data.operation == OP_SAMPLE) ||
                                  (s_data.operation == OP_TAIL));
    assign acc_coef  = accept && (s_data.operation == OP_COEF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b1;
            swap_reg  <= 1'b0;
            lgain_reg <= GAIN_RESET;
            rgain_reg <= GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WIDTH_MODE: mode_reg  <= cfg_data[0];
                REG_SWAP_EARS:  swap_reg  <= cfg_data[0];
                REG_LEFT_GAIN:  lgain_reg <= cfg_data[GAIN_W-1:0];
                REG_RIGHT_GAIN: rgain_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sample decode: code minus offset, only low byte in 8-bit mode
    logic [CODE_W-1:0]  lcode, rcode, offset;
    hist_pair_t         push_data;

    assign lcode  = mode_reg ? s_data.left_code  : {8'd0, s_data.left_code[7:0]};
    assign rcode  = mode_reg ? s_data.right_code : {8'd0, s_data.right_code[7:0]};
    assign offset = mode_reg ? OFFSET16 : OFFSET8;

    always_comb begin
        if (s_data.operation == OP_SAMPLE) begin
            push_data.left  = $signed({1'b0, lcode} - {1'b0, offset});
            push_data.right = $signed({1'b0, rcode} - {1'b0, offset});
        end else begin
            push_data = '0;
        end
    end

    // coefficient write, indices at or above TAPS are dropped
    logic [IW-1:0] cidx;
    logic          cidx_ok;
    logic [1:0]    tap_we;

    assign cidx    = IW'(s_data.coef_index);
    assign cidx_ok = ({1'b0, cidx} < (IW+1)'(TAPS));
    assign tap_we  = (acc_coef && cidx_ok) ? (s_data.coef_ear ? 2'b10 : 2'b01) : 2'b00;

    // read address: newest sample minus tap number, modulo TAPS
    logic [PW-1:0] hist_raddr;
    logic          rd_en;

    assign rd_en = (state_reg == ST_RUN);

    always_comb begin
        if (head_reg >= cnt_reg) begin
            hist_raddr = head_reg - cnt_reg;
        end else begin
            hist_raddr = PW'({1'b0, head_reg} + (PW+1)'(TAPS) - {1'b0, cnt_reg});
        end
    end

    hist_pair_t hist_q;
    tap_pair_t  tap_q;

    dchf_mem #(
        .TAPS(TAPS)
    ) u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hist_we   (acc_push),
        .hist_waddr(ptr_reg),
        .hist_wdata(push_data),
        .tap_we    (tap_we),
        .tap_waddr (cidx[PW-1:0]),
        .tap_wdata (s_data.coef_value),
        .rd_en     (rd_en),
        .hist_raddr(hist_raddr),
        .tap_raddr (cnt_reg),
        .hist_q    (hist_q),
        .tap_q     (tap_q)
    );

    lane_ctrl_t ctrl;

    assign ctrl.clear = acc_push;
    assign ctrl.dv    = rd_v_reg;
    assign ctrl.fin1  = (state_reg == ST_FIN1);
    assign ctrl.fin2  = (state_reg == ST_FIN2);

    logic [CODE_W-1:0] lres, rres;

    // swap exchanges the tap sets; gains stay with their ear
    dchf_lane #(
        .TAPS(TAPS)
    ) u_lane_l (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .sample(hist_q.left),
        .tap   (swap_reg ? tap_q.right : tap_q.left),
        .gain  (lgain_reg),
        .mode16(mode_reg),
        .result(lres)
    );

    dchf_lane #(
        .TAPS(TAPS)
    ) u_lane_r (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .sample(hist_q.right),
        .tap   (swap_reg ? tap_q.left : tap_q.right),
        .gain  (rgain_reg),
        .mode16(mode_reg),
        .result(rres)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drain_next = drain_reg;
        ptr_next   = ptr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc_push) begin
                    ptr_next   = (ptr_reg == PW'(TAPS - 1)) ? '0 : ptr_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PW'(TAPS - 1)) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // product, gain product and accumulate stages empty out
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2) begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            drain_reg <= '0;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            drain_reg <= drain_next;
            rd_v_reg  <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_push) begin
            head_reg <= ptr_reg;
        end
    end

    // output register: holds a finished result while the next request runs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg.left_out  <= lres;
            m_data_reg.right_out <= rres;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hdl/dchf_checker.sv -----
// Port-level checker for the stereo FIR and its bind to the top level.
module dchf_checker
    import dchf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input s_payload_t s_data,
    input logic       m_valid,
    input logic       m_ready,
    input m_payload_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a sample or tail request keeps the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_data.operation == OP_SAMPLE || s_data.operation == OP_TAIL) |=> !s_ready)
        else $error("request taken while filter busy");

    // a coefficient write does not block the next request
    a_coef_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == OP_COEF |=> s_ready)
        else $error("coefficient write stalled input");

    // no result appears right after a request with the output empty
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind dual_channel_hrtf_fir dchf_checker u_dchf_checker (.*);
